// ===== rtl/lcdbg_pkg.sv =====
package lcdbg_pkg;

	// Screen and memory geometry
	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 144;
	localparam int VRAM_BYTES    = 8192;
	localparam int FRAME_PIXELS  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int VRAM_AW       = $clog2(VRAM_BYTES);
	localparam int FRAME_AW      = $clog2(FRAME_PIXELS);
	localparam int XW            = $clog2(SCREEN_WIDTH);
	localparam int CLEAR_LEN     = (FRAME_PIXELS > VRAM_BYTES) ? FRAME_PIXELS : VRAM_BYTES;
	localparam int CLR_W         = $clog2(CLEAR_LEN + 1);

	// Phase lengths in dots
	localparam logic [9:0] DOTS_OAM    = 10'd80;
	localparam logic [9:0] DOTS_XFER   = 10'd172;
	localparam logic [9:0] DOTS_HBLANK = 10'd204;
	localparam logic [9:0] DOTS_LINE   = 10'd456;
	localparam logic [7:0] LAST_LINE   = 8'd153;

	// Video RAM offsets from the start of the video address space
	localparam logic [VRAM_AW-1:0] MAP_HI_BASE   = VRAM_AW'(16'h9C00 - 16'h8000);
	localparam logic [VRAM_AW-1:0] MAP_LO_BASE   = VRAM_AW'(16'h9800 - 16'h8000);
	localparam logic [VRAM_AW-1:0] SIGNED_BASE   = VRAM_AW'(16'h9000 - 16'h8000);

	// Pixel colours
	localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;
	localparam logic [31:0] ARGB_LIGHT = 32'h00AA_AAAA | 32'hFF00_0000;
	localparam logic [31:0] ARGB_DARK  = 32'h0055_5555 | 32'hFF00_0000;
	localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;

	// Configuration register reset values
	localparam logic [7:0] LCD_CONTROL_RST = 8'h91;
	localparam logic [7:0] BG_PALETTE_RST  = 8'hFC;

	// Control register bits
	localparam int LCDC_ON       = 7;
	localparam int LCDC_UNSIGNED = 4;
	localparam int LCDC_MAP_SEL  = 3;

	// Item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_LCD_CONTROL = 2'd0;
	localparam logic [1:0] REG_SCROLL_Y    = 2'd1;
	localparam logic [1:0] REG_SCROLL_X    = 2'd2;
	localparam logic [1:0] REG_BG_PALETTE  = 2'd3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MAP,
		ST_DATA,
		ST_PIX,
		ST_RESULT
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
		logic fetch_map;
		logic fetch_data;
		logic put_pixel;
		logic load_out;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic render_req;
		logic last_px;
	} dp_status_t;

	function automatic logic [31:0] shade_argb(input logic [1:0] shade);
		logic [31:0] c;
		case (shade)
			2'd0:    c = ARGB_WHITE;
			2'd1:    c = ARGB_LIGHT;
			2'd2:    c = ARGB_DARK;
			default: c = ARGB_BLACK;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/lcdbg_item_if.sv =====
interface lcdbg_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [6:0]  dots;
	logic [12:0] vram_offset;
	logic [7:0]  vram_data;
	logic [14:0] pixel_index;

	modport source (output valid, func, dots, vram_offset, vram_data, pixel_index,
		input ready);
	modport sink (input valid, func, dots, vram_offset, vram_data, pixel_index,
		output ready);
endinterface

// ===== rtl/lcdbg_result_if.sv =====
interface lcdbg_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  line_number;
	logic        in_vblank;
	logic [31:0] pixel_argb;

	modport source (output valid, mode, line_number, in_vblank, pixel_argb, input ready);
	modport sink (input valid, mode, line_number, in_vblank, pixel_argb, output ready);
endinterface

// ===== rtl/lcdbg_ctrl.sv =====
module lcdbg_ctrl
	import lcdbg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_EXEC;
			ST_EXEC:   state_d = status.render_req ? ST_MAP : ST_RESULT;
			ST_MAP:    state_d = ST_DATA;
			ST_DATA:   state_d = ST_PIX;
			ST_PIX:    state_d = status.last_px ? ST_RESULT : ST_MAP;
			ST_RESULT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EXEC:   cmd.exec       = 1'b1;
			ST_MAP:    cmd.fetch_map  = 1'b1;
			ST_DATA:   cmd.fetch_data = 1'b1;
			ST_PIX:    cmd.put_pixel  = 1'b1;
			ST_RESULT: cmd.load_out   = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/lcdbg_datapath.sv =====
module lcdbg_datapath
	import lcdbg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_status_t  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [1:0]  in_func,
	input  logic [6:0]  in_dots,
	input  logic [12:0] in_vram_offset,
	input  logic [7:0]  in_vram_data,
	input  logic [14:0] in_pixel_index,
	output logic [1:0]  out_mode,
	output logic [7:0]  out_line_number,
	output logic        out_in_vblank,
	output logic [31:0] out_pixel_argb
);

	// Configuration registers
	logic [7:0] lcd_control_q, scroll_y_q, scroll_x_q, bg_palette_q;

	// Timing state
	mode_t      mode_q, mode_d;
	logic [7:0] line_q, line_d;
	logic [9:0] dot_q, dot_d;

	// Latched item
	logic [1:0]  func_q;
	logic [6:0]  dots_q;
	logic [12:0] vram_offset_q;
	logic [7:0]  vram_data_q;
	logic [14:0] pixel_index_q;

	// Clearing pass and render state
	logic [CLR_W-1:0]    clear_cnt_q;
	logic [7:0]          py_q;
	logic [XW-1:0]       x_q;
	logic [FRAME_AW-1:0] frame_ptr_q;

	// Memories and their read data
	logic [7:0] vram_mem [VRAM_BYTES];
	logic [1:0] frame_mem [FRAME_PIXELS];
	logic [7:0] vram_rd_a_q, vram_rd_b_q;
	logic [1:0] frame_rd_q;

	logic [9:0]          dot_sum;
	logic [7:0]          line_inc;
	logic                xfer_end;
	logic [7:0]          px;
	logic [VRAM_AW-1:0]  map_addr, tile_base, vram_addr_a, vram_addr_b;
	logic [2:0]          bit_sel;
	logic [1:0]          cnum, shade;
	logic                vram_we, frame_we;
	logic [VRAM_AW-1:0]  vram_waddr;
	logic [7:0]          vram_wdata;
	logic [FRAME_AW-1:0] frame_waddr;
	logic [1:0]          frame_wdata;
	logic                read_oor;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_control_q <= LCD_CONTROL_RST;
			scroll_y_q    <= 8'd0;
			scroll_x_q    <= 8'd0;
			bg_palette_q  <= BG_PALETTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LCD_CONTROL: lcd_control_q <= cfg_data;
				REG_SCROLL_Y:    scroll_y_q    <= cfg_data;
				REG_SCROLL_X:    scroll_x_q    <= cfg_data;
				REG_BG_PALETTE:  bg_palette_q  <= cfg_data;
				default:         lcd_control_q <= lcd_control_q;
			endcase
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q        <= in_func;
			dots_q        <= in_dots;
			vram_offset_q <= in_vram_offset;
			vram_data_q   <= in_vram_data;
			pixel_index_q <= in_pixel_index;
		end
	end

	// Advance the dot counter by one tick, at most one mode change
	assign dot_sum  = dot_q + 10'(dots_q);
	assign line_inc = line_q + 8'd1;

	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		dot_d    = dot_sum;
		xfer_end = 1'b0;
		case (mode_q)
			MODE_OAM: begin
				if (dot_sum >= DOTS_OAM) begin
					dot_d  = dot_sum - DOTS_OAM;
					mode_d = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (dot_sum >= DOTS_XFER) begin
					dot_d    = dot_sum - DOTS_XFER;
					mode_d   = MODE_HBLANK;
					xfer_end = 1'b1;
				end
			end
			MODE_HBLANK: begin
				if (dot_sum >= DOTS_HBLANK) begin
					dot_d  = dot_sum - DOTS_HBLANK;
					line_d = line_inc;
					mode_d = (line_inc == 8'(SCREEN_HEIGHT)) ? MODE_VBLANK : MODE_OAM;
				end
			end
			default: begin
				if (dot_sum >= DOTS_LINE) begin
					dot_d  = dot_sum - DOTS_LINE;
					line_d = line_inc;
					if (line_inc > LAST_LINE) begin
						line_d = 8'd0;
						mode_d = MODE_OAM;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OAM;
			line_q <= 8'd0;
			dot_q  <= 10'd0;
		end else if (cmd.exec && func_q == FUNC_TICK) begin
			mode_q <= mode_d;
			line_q <= line_d;
			dot_q  <= dot_d;
		end
	end

	assign status.render_req = cmd.exec && func_q == FUNC_TICK && xfer_end
		&& lcd_control_q[LCDC_ON] && int'(line_q) < SCREEN_HEIGHT;
	assign status.last_px    = x_q == XW'(SCREEN_WIDTH - 1);
	assign status.clear_done = clear_cnt_q == CLR_W'(CLEAR_LEN - 1);

	// Sweep both memories after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cnt_q <= '0;
		end else if (cmd.clear) begin
			clear_cnt_q <= clear_cnt_q + 1'b1;
		end
	end

	// Render counters: start at column zero of the current line
	always_ff @(posedge clk) begin
		if (status.render_req) begin
			py_q        <= line_q + scroll_y_q;
			x_q         <= '0;
			frame_ptr_q <= FRAME_AW'(int'(line_q) * SCREEN_WIDTH);
		end else if (cmd.put_pixel) begin
			x_q         <= x_q + 1'b1;
			frame_ptr_q <= frame_ptr_q + 1'b1;
		end
	end

	// Tile map and tile data addressing
	assign px       = 8'(x_q) + scroll_x_q;
	assign map_addr = (lcd_control_q[LCDC_MAP_SEL] ? MAP_HI_BASE : MAP_LO_BASE)
		| VRAM_AW'({py_q[7:3], px[7:3]});
	assign tile_base = lcd_control_q[LCDC_UNSIGNED]
		? VRAM_AW'({vram_rd_a_q, 4'b0000})
		: SIGNED_BASE + VRAM_AW'({{5{vram_rd_a_q[7]}}, vram_rd_a_q, 4'b0000});
	assign vram_addr_a = cmd.fetch_map ? map_addr
		: {tile_base[VRAM_AW-1:4], py_q[2:0], 1'b0};
	assign vram_addr_b = {tile_base[VRAM_AW-1:4], py_q[2:0], 1'b1};

	// Pick the pixel's colour number and map it through the palette
	assign bit_sel = 3'd7 - px[2:0];
	assign cnum    = {vram_rd_b_q[bit_sel], vram_rd_a_q[bit_sel]};
	assign shade   = 2'(bg_palette_q >> {cnum, 1'b0});

	// Memory write selection
	always_comb begin
		vram_we     = 1'b0;
		vram_waddr  = clear_cnt_q[VRAM_AW-1:0];
		vram_wdata  = 8'd0;
		frame_we    = 1'b0;
		frame_waddr = clear_cnt_q[FRAME_AW-1:0];
		frame_wdata = 2'd0;
		if (cmd.clear) begin
			vram_we  = int'(clear_cnt_q) < VRAM_BYTES;
			frame_we = int'(clear_cnt_q) < FRAME_PIXELS;
		end else begin
			if (cmd.exec && func_q == FUNC_WRITE) begin
				vram_we    = 1'b1;
				vram_waddr = vram_offset_q[VRAM_AW-1:0];
				vram_wdata = vram_data_q;
			end
			if (cmd.put_pixel) begin
				frame_we    = 1'b1;
				frame_waddr = frame_ptr_q;
				frame_wdata = shade;
			end
		end
	end

	// Video RAM: one write port, two registered read ports loaded on fetch cycles
	always_ff @(posedge clk) begin
		if (vram_we) begin
			vram_mem[vram_waddr] <= vram_wdata;
		end
		if (cmd.fetch_map || cmd.fetch_data) begin
			vram_rd_a_q <= vram_mem[vram_addr_a];
		end
		if (cmd.fetch_data) begin
			vram_rd_b_q <= vram_mem[vram_addr_b];
		end
	end

	// Frame store: one write port, read port follows the latched pixel index
	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[frame_waddr] <= frame_wdata;
		end
		frame_rd_q <= frame_mem[FRAME_AW'(pixel_index_q)];
	end

	assign read_oor = int'(pixel_index_q) >= FRAME_PIXELS;

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_mode        <= mode_q;
			out_line_number <= line_q;
			out_in_vblank   <= mode_q == MODE_VBLANK;
			if (func_q != FUNC_READ) begin
				out_pixel_argb <= 32'd0;
			end else if (read_oor) begin
				out_pixel_argb <= ARGB_WHITE;
			end else begin
				out_pixel_argb <= shade_argb(frame_rd_q);
			end
		end
	end

endmodule

// ===== rtl/lcd_timing_background_renderer.sv =====
// LCD timing generator with a background tile-map line renderer. After reset
// the block sweeps its frame store and video RAM to zero, one entry a cycle;
// item ready stays low meanwhile but configuration writes are taken. A tick,
// video RAM write or pixel read then passes from accepted beat to result beat
// through accept, execute and load of the output register, one item at a
// time; a finished result waits in the output register while the next item
// is accepted. A tick that ends pixel transfer with the display on also
// renders the current 160-pixel line, each pixel by a tile map fetch, then
// both tile data bytes at once on the two video RAM read ports, then the
// frame store write. Configuration may only be written while no item is
// open.
module lcd_timing_background_renderer
	import lcdbg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	lcdbg_item_if.sink     item,
	lcdbg_result_if.source result
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	lcdbg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lcdbg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_func         (item.func),
		.in_dots         (item.dots),
		.in_vram_offset  (item.vram_offset),
		.in_vram_data    (item.vram_data),
		.in_pixel_index  (item.pixel_index),
		.out_mode        (result.mode),
		.out_line_number (result.line_number),
		.out_in_vblank   (result.in_vblank),
		.out_pixel_argb  (result.pixel_argb)
	);

endmodule

// ===== rtl/lcdbg_checker.sv =====
module lcdbg_checker
	import lcdbg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  mode,
	input logic [7:0]  line_number,
	input logic        in_vblank,
	input logic [31:0] pixel_argb
);

	// A result beat stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// The vblank flag follows the reported mode
	a_vblank_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_vblank == (mode == MODE_VBLANK))
		else $error("in_vblank disagrees with mode");

	// Visible modes only on visible lines, vertical blank only below them
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode == MODE_VBLANK)
			? (int'(line_number) >= SCREEN_HEIGHT && line_number <= LAST_LINE)
			: int'(line_number) < SCREEN_HEIGHT)
		else $error("line number outside its mode's range");

	// Colour is either absent or opaque
	a_argb_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_argb == 32'd0 || pixel_argb[31:24] == 8'hFF)
		else $error("malformed pixel colour");

endmodule

bind lcd_timing_background_renderer lcdbg_checker u_lcdbg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.mode        (result.mode),
	.line_number (result.line_number),
	.in_vblank   (result.in_vblank),
	.pixel_argb  (result.pixel_argb)
);
